// ----- hw/rtl/ieval_pkg.sv -----
// ----------------------------------------------------------------------------
// ieval_pkg
// Shared constants, codes and controller/datapath signal groups for the
// infix expression evaluator.
// ----------------------------------------------------------------------------
package ieval_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] CH_MUL  = 8'd42;
  localparam logic [7:0] CH_ADD  = 8'd43;
  localparam logic [7:0] CH_SUB  = 8'd45;
  localparam logic [7:0] CH_DIV  = 8'd47;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  // Operator codes; bit 1 is the precedence.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] KIND_ONE   = 3'd0;
  localparam logic [2:0] KIND_TWO   = 3'd1;
  localparam logic [2:0] KIND_FINAL = 3'd2;
  localparam logic [2:0] KIND_DIVZ  = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  localparam logic [1:0] EMIT_SNAP  = 2'd0;
  localparam logic [1:0] EMIT_FINAL = 2'd1;
  localparam logic [1:0] EMIT_DIVZ  = 2'd2;
  localparam logic [1:0] EMIT_EMPTY = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       acc_digit;
    logic       push_acc;
    logic       push_op;
    logic       alu_start;
    logic       alu_wb;
    logic       emit;
    logic       clear;
    logic       min_prec;
    logic [1:0] emit_sel;
  } ieval_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic in_prec;
    logic last;
    logic digits_seen;
    logic can_reduce;
    logic div_zero;
    logic alu_done;
    logic out_free;
  } ieval_sts_t;

endpackage

// ----- hw/rtl/ieval_if.sv -----
// ----------------------------------------------------------------------------
// ieval_if
// Valid/ready channels carrying input characters and evaluation results.
// ----------------------------------------------------------------------------
interface ieval_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
  modport mon    (input valid, input char_code, input last_char, input ready);
endinterface

interface ieval_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] value_low;
  logic signed [31:0] value_top;
  logic               expr_done;

  modport source (output valid, output kind, output value_low, output value_top,
                  output expr_done, input ready);
  modport sink   (input valid, input kind, input value_low, input value_top,
                  input expr_done, output ready);
  modport mon    (input valid, input kind, input value_low, input value_top,
                  input expr_done, input ready);
endinterface

// ----- hw/rtl/ieval_alu.sv -----
// ----------------------------------------------------------------------------
// ieval_alu
// Arithmetic unit: add and subtract registered directly on start, shift-add
// multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
module ieval_alu #(
  parameter int VALUE_WIDTH = ieval_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             op,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [1:0]    op_r;
  logic          neg;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [W-1:0]  z;

  logic [W-1:0]  mul_next;
  logic [W:0]    shifted;
  logic [W:0]    trial;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  quo_next;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;

  always_comb begin
    mag_a    = a[W-1] ? (~a + W'(1)) : a;
    mag_b    = b[W-1] ? (~b + W'(1)) : b;
    mul_next = y[0] ? (z + x) : z;
    shifted  = {x, y[W-1]};
    trial    = shifted - {1'b0, z};
    if (!trial[W]) begin
      rem_next = trial[W-1:0];
      quo_next = {y[W-2:0], 1'b1};
    end else begin
      rem_next = shifted[W-1:0];
      quo_next = {y[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      op_r <= op;
      neg  <= a[W-1] ^ b[W-1];
      cnt  <= CW'(W - 1);
      case (op)
        ieval_pkg::OP_ADD: begin
          result <= a + b;
          done   <= 1'b1;
        end
        ieval_pkg::OP_SUB: begin
          result <= a - b;
          done   <= 1'b1;
        end
        ieval_pkg::OP_MUL: begin
          x    <= a;
          y    <= b;
          z    <= '0;
          busy <= 1'b1;
          done <= 1'b0;
        end
        default: begin
          x    <= '0;
          y    <= mag_a;
          z    <= mag_b;
          busy <= 1'b1;
          done <= 1'b0;
        end
      endcase
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (op_r == ieval_pkg::OP_MUL) begin
        x <= x << 1;
        y <= y >> 1;
        z <= mul_next;
      end else begin
        x <= rem_next;
        y <= quo_next;
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (op_r == ieval_pkg::OP_MUL) begin
          result <= mul_next;
        end else begin
          result <= neg ? (~quo_next + W'(1)) : quo_next;
        end
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/ieval_dp.sv -----
// ----------------------------------------------------------------------------
// ieval_dp
// Datapath: input latch, number and operator stacks, number accumulator,
// arithmetic unit and the output register.
// ----------------------------------------------------------------------------
module ieval_dp #(
  parameter int VALUE_WIDTH = ieval_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ieval_pkg::ieval_cmd_t  cmd,
  output ieval_pkg::ieval_sts_t  sts,
  input  logic [7:0]             char_code,
  input  logic                   last_char,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             kind,
  output logic signed [31:0]     value_low,
  output logic signed [31:0]     value_top,
  output logic                   expr_done
);

  localparam int W = VALUE_WIDTH;

  logic [7:0]   ch;
  logic         last;
  logic [W-1:0] stk [3];
  logic [1:0]   ncnt;
  logic [1:0]   ops [2];
  logic [1:0]   ocnt;
  logic [W-1:0] acc;
  logic         dseen;

  logic         is_digit;
  logic         is_op;
  logic [1:0]   in_op;
  logic [W-1:0] digit;
  logic         alu_done;
  logic [W-1:0] alu_result;

  logic [2:0]   kind_next;
  logic         done_next;
  logic [W-1:0] low_sel;
  logic [W-1:0] top_sel;
  logic [31:0]  low_ext;
  logic [31:0]  top_ext;

  always_comb begin
    is_digit = (ch >= ieval_pkg::CH_ZERO) && (ch <= ieval_pkg::CH_NINE);
    digit    = W'(ch - ieval_pkg::CH_ZERO);
    unique case (ch)
      ieval_pkg::CH_ADD: begin
        is_op = 1'b1;
        in_op = ieval_pkg::OP_ADD;
      end
      ieval_pkg::CH_SUB: begin
        is_op = 1'b1;
        in_op = ieval_pkg::OP_SUB;
      end
      ieval_pkg::CH_MUL: begin
        is_op = 1'b1;
        in_op = ieval_pkg::OP_MUL;
      end
      ieval_pkg::CH_DIV: begin
        is_op = 1'b1;
        in_op = ieval_pkg::OP_DIV;
      end
      default: begin
        is_op = 1'b0;
        in_op = ieval_pkg::OP_ADD;
      end
    endcase
  end

  ieval_alu #(
    .VALUE_WIDTH(W)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.alu_start),
    .op     (ops[0]),
    .a      (stk[1]),
    .b      (stk[0]),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    sts.is_digit    = is_digit;
    sts.is_op       = is_op;
    sts.in_prec     = in_op[1];
    sts.last        = last;
    sts.digits_seen = dseen;
    sts.can_reduce  = (ocnt != 2'd0) && (ocnt <= 2'd2) && (ncnt >= 2'd2)
                      && (ops[0][1] >= cmd.min_prec);
    sts.div_zero    = (ops[0] == ieval_pkg::OP_DIV) && (stk[0] == '0);
    sts.alu_done    = alu_done;
    sts.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch   <= char_code;
      last <= last_char;
    end
  end

  // Both stacks keep their top entry at index 0.
  always_ff @(posedge clk) begin
    if (cmd.push_acc && (ncnt != 2'd3)) begin
      stk[2] <= stk[1];
      stk[1] <= stk[0];
      stk[0] <= acc;
    end else if (cmd.alu_wb) begin
      stk[1] <= stk[2];
      stk[0] <= alu_result;
    end
    if (cmd.push_op && (ocnt < 2'd2)) begin
      ops[1] <= ops[0];
      ops[0] <= in_op;
    end else if (cmd.alu_wb) begin
      ops[0] <= ops[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      ncnt  <= 2'd0;
      ocnt  <= 2'd0;
      acc   <= '0;
      dseen <= 1'b0;
    end else begin
      if (cmd.acc_digit) begin
        acc   <= (acc << 3) + (acc << 1) + digit;
        dseen <= 1'b1;
      end
      if (cmd.push_acc) begin
        if (ncnt != 2'd3) begin
          ncnt <= ncnt + 2'd1;
        end
        acc   <= '0;
        dseen <= 1'b0;
      end
      if (cmd.push_op && (ocnt < 2'd2)) begin
        ocnt <= ocnt + 2'd1;
      end
      if (cmd.alu_wb) begin
        ncnt <= ncnt - 2'd1;
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  always_comb begin
    low_sel   = '0;
    top_sel   = '0;
    done_next = 1'b1;
    case (cmd.emit_sel)
      ieval_pkg::EMIT_SNAP: begin
        done_next = 1'b0;
        if (ncnt >= 2'd2) begin
          kind_next = ieval_pkg::KIND_TWO;
          low_sel   = stk[1];
          top_sel   = stk[0];
        end else begin
          kind_next = ieval_pkg::KIND_ONE;
          if (ncnt == 2'd1) begin
            top_sel = stk[0];
          end
        end
      end
      ieval_pkg::EMIT_FINAL: begin
        kind_next = ieval_pkg::KIND_FINAL;
        if (ncnt != 2'd0) begin
          top_sel = stk[0];
        end
      end
      ieval_pkg::EMIT_DIVZ: kind_next = ieval_pkg::KIND_DIVZ;
      default:              kind_next = ieval_pkg::KIND_EMPTY;
    endcase
  end

  if (W >= 32) begin : g_cut
    assign low_ext = low_sel[31:0];
    assign top_ext = top_sel[31:0];
  end else begin : g_ext
    assign low_ext = {{(32 - W){low_sel[W-1]}}, low_sel};
    assign top_ext = {{(32 - W){top_sel[W-1]}}, top_sel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind      <= kind_next;
      value_low <= low_ext;
      value_top <= top_ext;
      expr_done <= done_next;
    end
  end

endmodule

// ----- hw/rtl/ieval_ctrl.sv -----
// ----------------------------------------------------------------------------
// ieval_ctrl
// Controller: sequences character decode, operator reduction, arithmetic
// and result emission.
// ----------------------------------------------------------------------------
module ieval_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output ieval_pkg::ieval_cmd_t cmd,
  input  ieval_pkg::ieval_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_LAST   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_ALU    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       final_mode;
  logic       final_mode_next;
  logic [1:0] emit_sel;
  logic [1:0] emit_sel_next;

  always_comb begin
    state_next      = state;
    final_mode_next = final_mode;
    emit_sel_next   = emit_sel;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.emit_sel    = emit_sel;
    cmd.min_prec    = !final_mode && sts.in_prec;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_digit) begin
          cmd.acc_digit = 1'b1;
          state_next    = sts.last ? S_LAST : S_IDLE;
        end else if (sts.is_op) begin
          if (!sts.digits_seen) begin
            emit_sel_next = ieval_pkg::EMIT_EMPTY;
            state_next    = S_EMIT;
          end else begin
            cmd.push_acc    = 1'b1;
            final_mode_next = 1'b0;
            state_next      = S_CHECK;
          end
        end else begin
          state_next = sts.last ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        if (!sts.digits_seen) begin
          emit_sel_next = ieval_pkg::EMIT_EMPTY;
          state_next    = S_EMIT;
        end else begin
          cmd.push_acc    = 1'b1;
          final_mode_next = 1'b1;
          state_next      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.can_reduce) begin
          if (sts.div_zero) begin
            emit_sel_next = ieval_pkg::EMIT_DIVZ;
            state_next    = S_EMIT;
          end else begin
            cmd.alu_start = 1'b1;
            state_next    = S_ALU;
          end
        end else if (final_mode) begin
          emit_sel_next = ieval_pkg::EMIT_FINAL;
          state_next    = S_EMIT;
        end else begin
          cmd.push_op = 1'b1;
          if (sts.last) begin
            state_next = S_LAST;
          end else begin
            emit_sel_next = ieval_pkg::EMIT_SNAP;
            state_next    = S_EMIT;
          end
        end
      end
      S_ALU: begin
        if (sts.alu_done) begin
          cmd.alu_wb = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.clear  = (emit_sel != ieval_pkg::EMIT_SNAP);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      final_mode <= 1'b0;
      emit_sel   <= ieval_pkg::EMIT_SNAP;
    end else begin
      state      <= state_next;
      final_mode <= final_mode_next;
      emit_sel   <= emit_sel_next;
    end
  end

endmodule

// ----- hw/rtl/infix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Evaluates an infix expression of decimal numbers and + - * / delivered one
// character per item, snapshots after non-last operators and an end result.
//
//   Channel     Role   Payload                                   Handshake
//   char_in     sink   char_code[7:0], last_char                 valid/ready
//   result_out  source kind[2:0], value_low, value_top, expr_done valid/ready
//
// One item is processed at a time. A digit or other character is loaded and
// decoded; an operator or last character then also passes the reduction
// check, the arithmetic unit for each reduction (bit-serial for multiply and
// divide) and the emission step. Reset is synchronous and clears the counts,
// the accumulator and the output valid flag. A stalled result blocks only the
// next emission; input items are still taken until then.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int VALUE_WIDTH = ieval_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ieval_in_if.sink    char_in,
  ieval_out_if.source result_out
);

  ieval_pkg::ieval_cmd_t cmd;
  ieval_pkg::ieval_sts_t sts;

  ieval_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_ready (char_in.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ieval_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (char_in.char_code),
    .last_char (char_in.last_char),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .kind      (result_out.kind),
    .value_low (result_out.value_low),
    .value_top (result_out.value_top),
    .expr_done (result_out.expr_done)
  );

endmodule

// ----- hw/rtl/ieval_checker.sv -----
// ----------------------------------------------------------------------------
// ieval_checker
// Port-level checks on the evaluator's channels, bound to the top level.
// ----------------------------------------------------------------------------
module ieval_checker (
  input logic               clk,
  input logic               rst,
  input logic               char_valid,
  input logic               char_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic [2:0]         kind,
  input logic signed [31:0] value_low,
  input logic signed [31:0] value_top,
  input logic               expr_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(kind) && $stable(value_top)
      && $stable(value_low) && $stable(expr_done))
    else $error("Result changed while stalled.");

  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      expr_done == ((kind == ieval_pkg::KIND_FINAL)
        || (kind == ieval_pkg::KIND_DIVZ)
        || (kind == ieval_pkg::KIND_EMPTY)))
    else $error("End flag does not match the result kind.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((kind == ieval_pkg::KIND_DIVZ)
      || (kind == ieval_pkg::KIND_EMPTY)) |->
      (value_top == 32'sd0) && (value_low == 32'sd0))
    else $error("Error result carries a value.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_ready |=> !char_ready)
    else $error("Second item taken while one is in progress.");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result valid after reset.");

endmodule

bind infix_expression_evaluator ieval_checker u_ieval_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_in.valid),
  .char_ready   (char_in.ready),
  .result_valid (result_out.valid),
  .result_ready (result_out.ready),
  .kind         (result_out.kind),
  .value_low    (result_out.value_low),
  .value_top    (result_out.value_top),
  .expr_done    (result_out.expr_done)
);

// ----- tb/sv/infix_expression_evaluator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_tb
// Self-checking testbench for the infix expression evaluator.
// A queue of character items feeds a valid/ready driver. Each accepted item
// is run through a two-stack evaluator kept in the testbench. The results it
// predicts are compared, field by field and in order, with the results the
// block delivers. Both sides idle at random, and the receiver holds off once
// for a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int CHAR_TARGET = 950;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] low;
    logic [31:0] top;
    logic        done;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_hold = 1'b0;

  int errors = 0;
  int results_seen = 0;
  int chars_sent = 0;
  int chars_queued = 0;
  int cycle_count = 0;

  char_item_t   pending_chars[$];
  eval_result_t expected_results[$];

  logic [31:0] num_stk [3];
  logic [1:0]  op_stk [2];
  int          num_cnt = 0;
  int          op_cnt = 0;
  logic [31:0] acc = '0;
  logic        have_digits = 1'b0;

  ieval_in_if  char_in ();
  ieval_out_if result_out ();

  infix_expression_evaluator #(.VALUE_WIDTH(32)) dut (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .result_out (result_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    errors++;
  endtask

  function automatic void clear_eval();
    num_stk = '{default: '0};
    op_stk = '{default: '0};
    num_cnt = 0;
    op_cnt = 0;
    acc = '0;
    have_digits = 1'b0;
  endfunction

  function automatic void push_num(input logic [31:0] v);
    if (num_cnt < 3) begin
      num_stk[num_cnt] = v;
      num_cnt++;
    end
  endfunction

  function automatic void push_result(input logic [2:0] kind, input logic [31:0] low,
                                      input logic [31:0] top, input logic done);
    expected_results.push_back('{kind, low, top, done});
  endfunction

  function automatic bit reduce_ops(input logic min_prec);
    logic [1:0]  op;
    logic [31:0] lhs, rhs, res, mag_l, mag_r, quot;
    bit          more;
    more = 1'b1;
    while (more && op_cnt > 0 && num_cnt >= 2) begin
      op = op_stk[op_cnt - 1];
      if (op[1] < min_prec) begin
        more = 1'b0;
      end else begin
        lhs = num_stk[num_cnt - 2];
        rhs = num_stk[num_cnt - 1];
        case (op)
          ieval_pkg::OP_ADD: res = lhs + rhs;
          ieval_pkg::OP_SUB: res = lhs - rhs;
          ieval_pkg::OP_MUL: res = lhs * rhs;
          default: begin
            if (rhs == '0) return 1'b0;
            mag_l = lhs[31] ? -lhs : lhs;
            mag_r = rhs[31] ? -rhs : rhs;
            quot = mag_l / mag_r;
            res = (lhs[31] ^ rhs[31]) ? -quot : quot;
          end
        endcase
        op_cnt--;
        num_cnt--;
        num_stk[num_cnt - 1] = res;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit is_op_char(input logic [7:0] code);
    return code == ieval_pkg::CH_ADD || code == ieval_pkg::CH_SUB ||
           code == ieval_pkg::CH_MUL || code == ieval_pkg::CH_DIV;
  endfunction

  function automatic void evaluate_char(input logic [7:0] code, input logic last);
    logic [1:0]  op;
    logic [31:0] res;
    if (code >= ieval_pkg::CH_ZERO && code <= ieval_pkg::CH_NINE) begin
      acc = acc * 32'd10 + 32'(code - ieval_pkg::CH_ZERO);
      have_digits = 1'b1;
    end else if (is_op_char(code)) begin
      case (code)
        ieval_pkg::CH_ADD: op = ieval_pkg::OP_ADD;
        ieval_pkg::CH_SUB: op = ieval_pkg::OP_SUB;
        ieval_pkg::CH_MUL: op = ieval_pkg::OP_MUL;
        default:           op = ieval_pkg::OP_DIV;
      endcase
      if (!have_digits) begin
        clear_eval();
        push_result(ieval_pkg::KIND_EMPTY, '0, '0, 1'b1);
        return;
      end
      push_num(acc);
      acc = '0;
      have_digits = 1'b0;
      if (!reduce_ops(op[1])) begin
        clear_eval();
        push_result(ieval_pkg::KIND_DIVZ, '0, '0, 1'b1);
        return;
      end
      if (op_cnt < 2) begin
        op_stk[op_cnt] = op;
        op_cnt++;
      end
      if (!last) begin
        if (num_cnt >= 2) begin
          push_result(ieval_pkg::KIND_TWO, num_stk[num_cnt - 2], num_stk[num_cnt - 1],
                      1'b0);
        end else if (num_cnt == 1) begin
          push_result(ieval_pkg::KIND_ONE, '0, num_stk[0], 1'b0);
        end else begin
          push_result(ieval_pkg::KIND_ONE, '0, '0, 1'b0);
        end
        return;
      end
    end
    if (last) begin
      if (!have_digits) begin
        clear_eval();
        push_result(ieval_pkg::KIND_EMPTY, '0, '0, 1'b1);
        return;
      end
      push_num(acc);
      if (!reduce_ops(1'b0)) begin
        clear_eval();
        push_result(ieval_pkg::KIND_DIVZ, '0, '0, 1'b1);
        return;
      end
      res = (num_cnt >= 1) ? num_stk[num_cnt - 1] : '0;
      clear_eval();
      push_result(ieval_pkg::KIND_FINAL, '0, res, 1'b1);
    end
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0:       return ieval_pkg::CH_ADD;
      1:       return ieval_pkg::CH_SUB;
      2:       return ieval_pkg::CH_MUL;
      default: return ieval_pkg::CH_DIV;
    endcase
  endfunction

  function automatic logic [7:0] random_other();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while ((c >= ieval_pkg::CH_ZERO && c <= ieval_pkg::CH_NINE) || is_op_char(c)) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic void add_char(input logic [7:0] code, input logic last);
    pending_chars.push_back('{code, last});
    chars_queued++;
  endfunction

  function automatic void add_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], last && (i == s.len() - 1));
    end
  endfunction

  function automatic void add_number(input logic last);
    int sel;
    int ndig;
    sel = $urandom_range(0, 19);
    if (sel >= 16 && sel <= 17) begin
      case ($urandom_range(0, 4))
        0:       add_text("2147483647", last);
        1:       add_text("2147483648", last);
        2:       add_text("4294967295", last);
        3:       add_text("4294967296", last);
        default: add_text("99999999999", last);
      endcase
      return;
    end
    if (sel < 10) ndig = $urandom_range(1, 3);
    else if (sel < 13) ndig = 0;
    else if (sel < 16) ndig = 10;
    else ndig = $urandom_range(4, 9);
    if (ndig == 0) begin
      add_char(ieval_pkg::CH_ZERO, last);
    end else begin
      for (int i = 0; i < ndig; i++) begin
        add_char(8'(ieval_pkg::CH_ZERO + $urandom_range(0, 9)), last && (i == ndig - 1));
      end
    end
  endfunction

  always @(posedge clk) begin : drive_chars
    char_item_t nxt;
    bit         idle;
    if (rst) begin
      char_in.valid     <= 1'b0;
      char_in.char_code <= 8'h00;
      char_in.last_char <= 1'b0;
    end else begin
      if (char_in.valid && char_in.ready) begin
        evaluate_char(char_in.char_code, char_in.last_char);
        chars_sent++;
      end
      if (!char_in.valid || char_in.ready) begin
        idle = !rx_hold && !(chars_sent >= 400 && chars_sent < 520) &&
               ($urandom_range(0, 99) < 29);
        if (pending_chars.size() > 0 && !idle) begin
          nxt = pending_chars.pop_front();
          char_in.valid <= 1'b1;
          char_in.char_code <= nxt.code;
          char_in.last_char <= nxt.last;
        end else begin
          char_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    eval_result_t got;
    eval_result_t want;
    bit           bad;
    bit           stall;
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        results_seen++;
        got = '{result_out.kind, result_out.value_low, result_out.value_top,
                result_out.expr_done};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d low %h top %h done %0d",
                                    got.kind, got.low, got.top, got.done));
        end else begin
          want = expected_results.pop_front();
          bad = 1'b0;
          if (got.kind !== want.kind) bad = 1'b1;
          if (got.low !== want.low) bad = 1'b1;
          if (got.top !== want.top) bad = 1'b1;
          if (got.done !== want.done) bad = 1'b1;
          if (bad) begin
            report_mismatch($sformatf(
              "result %0d: kind %0d/%0d low %h/%h top %h/%h done %0d/%0d (got/exp)",
              results_seen, got.kind, want.kind, got.low, want.low, got.top, want.top,
              got.done, want.done));
          end
        end
      end
      stall = rx_hold || (!(results_seen >= 150 && results_seen < 230) &&
                          ($urandom_range(0, 99) < 29));
      result_out.ready <= !stall;
    end
  end

  initial begin : receiver_hold
    wait (results_seen >= 40);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int nterms;
    bit fin;

    add_char(8'h00, 1'b0);
    add_text("95+6*7/0-", 1'b0);
    add_char(ieval_pkg::CH_SUB, 1'b0);
    add_text("3/2", 1'b0);
    add_char(8'h80, 1'b1);
    add_text("7-9*2", 1'b1);
    add_text("5", 1'b0);
    add_char(ieval_pkg::CH_ADD, 1'b1);
    add_text("8/0", 1'b0);
    add_char(ieval_pkg::CH_MUL, 1'b1);
    add_char(8'hFF, 1'b1);

    while (chars_queued < CHAR_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        nterms = $urandom_range(1, 5);
        for (int t = 0; t < nterms; t++) begin
          fin = (t == nterms - 1);
          if (fin && $urandom_range(0, 9) == 0) begin
            add_number(1'b0);
            add_char(random_other(), 1'b1);
          end else begin
            add_number(fin);
          end
          if (!fin) begin
            if ($urandom_range(0, 9) == 0) add_char(random_other(), 1'b0);
            add_char(random_op(), 1'b0);
          end
        end
      end else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0:       add_text("2147483648/4294967295", 1'b1);
          1:       add_text("4294967295*2147483647", 1'b1);
          default: add_text("2147483647+1-0", 1'b1);
        endcase
      end else if (pick < 92) begin
        case ($urandom_range(0, 3))
          0: add_char(random_op(), 1'($urandom_range(0, 1)));
          1: begin
            add_number(1'b0);
            add_char(random_op(), 1'b0);
            add_char(random_op(), 1'b0);
          end
          2: begin
            add_number(1'b0);
            add_char(random_op(), 1'b1);
          end
          default: begin
            add_number(1'b0);
            add_char(ieval_pkg::CH_DIV, 1'b0);
            add_char(ieval_pkg::CH_ZERO, 1'b0);
            add_char(random_op(), 1'b1);
          end
        endcase
      end else begin
        add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (pending_chars.size() == 0 && !char_in.valid);
    wait (expected_results.size() == 0);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
